// ===== hdl/ceal_pkg.sv =====
// Package for the complex element-wise ALU.
// Holds the operation codes and configuration register indexes.
// No dependencies.
package ceal_pkg;

  // Operation code carried with each input beat.
  typedef logic [1:0] op_t;
  localparam op_t OP_MUL   = 2'd0;
  localparam op_t OP_DIV   = 2'd1;
  localparam op_t OP_SCALE = 2'd2;
  localparam op_t OP_ADD   = 2'd3;

  // Configuration register indexes.
  typedef logic cfg_idx_t;
  localparam cfg_idx_t REG_CONST_REAL = 1'b0;
  localparam cfg_idx_t REG_CONST_IMAG = 1'b1;

endpackage

// ===== hdl/complex_elementwise_alu_top.sv =====
// Top level of the complex element-wise ALU: multiply, divide, scale and add.
// Depends on ceal_pkg for operation codes and register indexes.
//
// Usage:
// - Input beats are taken at every rising edge with start high and busy low.
//   busy is always low, so a new beat may be offered in every cycle.
// - Each beat gives one result beat, marked by out_valid for one cycle, in
//   the order the inputs were taken. The receiver cannot stall the block.
// - Throughput is one beat per cycle for every operation.
// - The latency is set by the restoring divider: one quotient bit per
//   pipeline stage, DATA_WIDTH + 1 stages, behind four stages of input
//   capture, products, sums and divider setup. All operations travel the
//   same pipeline so results stay in order.
// - cfg_we writes const_real (index 0) or const_imag (index 1) from
//   cfg_wdata; write them only while no beat is in flight.
// - A synchronous reset clears the constants and all valid bits; beats in
//   flight are dropped.
module complex_elementwise_alu_top #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  ceal_pkg::op_t                in_operation,
  input  logic signed [DATA_WIDTH-1:0] in_a_real,
  input  logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  logic signed [DATA_WIDTH-1:0] in_b_real,
  input  logic signed [DATA_WIDTH-1:0] in_b_imag,
  input  logic                         in_last_in,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_real,
  output logic signed [DATA_WIDTH-1:0] out_res_imag,
  output logic                         out_saturated,
  output logic                         out_divide_by_zero,
  output logic                         out_last_out,
  input  logic                         cfg_we,
  input  ceal_pkg::cfg_idx_t           cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_wdata
);
  import ceal_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;          // product width
  localparam int NW  = 2 * W + 1;      // sum and magnitude width
  localparam int DW  = 2 * W + 1;      // divisor width
  localparam int QB  = W + 1;          // quotient bits
  localparam int XW  = NW + F;         // scaled dividend width
  localparam int CW  = 3 * W + 3 + F;  // overflow compare width
  localparam int LAT = QB + 5;

  localparam logic [NW-1:0] POS_MAX = NW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [NW-1:0] NEG_MAG = NW'(64'd1 << (W - 1));
  localparam logic [NW-1:0] RND     = NW'((64'd1 << F) - 64'd1);

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic                last;
    logic signed [W-1:0] ar;
    logic signed [W-1:0] ai;
    logic signed [W-1:0] br;
    logic signed [W-1:0] bi;
    logic signed [W-1:0] cr;
    logic signed [W-1:0] ci;
  } s1_t;

  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic                 last;
    logic signed [PW-1:0] pr_rr;
    logic signed [PW-1:0] pr_ii;
    logic signed [PW-1:0] pr_ri;
    logic signed [PW-1:0] pr_ir;
    logic signed [PW-1:0] sq_r;
    logic signed [PW-1:0] sq_i;
    logic signed [W:0]    sum_r;
    logic signed [W:0]    sum_i;
  } s2_t;

  typedef struct packed {
    logic                valid;
    logic                div;
    logic                dz;
    logic                last;
    logic [1:0]          neg;
    logic [1:0][NW-1:0]  mag;
    logic [DW-1:0]       d;
  } s3_t;

  typedef struct packed {
    logic                valid;
    logic                div;
    logic                dz;
    logic                last;
    logic [1:0]          neg;
    logic [1:0]          ovf;
    logic [1:0][DW-1:0]  rem;
    logic [1:0][QB-1:0]  xl;
    logic [1:0][QB-1:0]  q;
    logic [1:0][NW-1:0]  mag;
    logic [DW-1:0]       d;
  } dv_t;

  logic signed [W-1:0] const_real_r;
  logic signed [W-1:0] const_imag_r;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  dv_t dv_r   [0:QB];
  dv_t dv_nxt [0:QB];

  logic                out_valid_r, out_valid_nxt;
  logic signed [W-1:0] out_res_real_r, out_res_real_nxt;
  logic signed [W-1:0] out_res_imag_r, out_res_imag_nxt;
  logic                out_sat_r, out_sat_nxt;
  logic                out_dz_r, out_dz_nxt;
  logic                out_last_r, out_last_nxt;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_real_r <= '0;
      const_imag_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONST_REAL: const_real_r <= $signed(cfg_wdata);
        REG_CONST_IMAG: const_imag_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Stage 1: capture the beat; scale takes the constant as its b operand.
  always_comb begin
    s1_nxt.valid = start && !busy;
    s1_nxt.op    = in_operation;
    s1_nxt.last  = in_last_in;
    s1_nxt.ar    = in_a_real;
    s1_nxt.ai    = in_a_imag;
    s1_nxt.br    = (in_operation == OP_SCALE) ? const_real_r : in_b_real;
    s1_nxt.bi    = (in_operation == OP_SCALE) ? const_imag_r : in_b_imag;
    s1_nxt.cr    = const_real_r;
    s1_nxt.ci    = const_imag_r;
  end

  // Stage 2: all cross products, the divisor squares and the constant sums.
  always_comb begin
    s2_nxt.valid = s1_r.valid;
    s2_nxt.op    = s1_r.op;
    s2_nxt.last  = s1_r.last;
    s2_nxt.pr_rr = PW'(s1_r.ar) * PW'(s1_r.br);
    s2_nxt.pr_ii = PW'(s1_r.ai) * PW'(s1_r.bi);
    s2_nxt.pr_ri = PW'(s1_r.ar) * PW'(s1_r.bi);
    s2_nxt.pr_ir = PW'(s1_r.ai) * PW'(s1_r.br);
    s2_nxt.sq_r  = PW'(s1_r.br) * PW'(s1_r.br);
    s2_nxt.sq_i  = PW'(s1_r.bi) * PW'(s1_r.bi);
    s2_nxt.sum_r = (W + 1)'(s1_r.ar) + (W + 1)'(s1_r.cr);
    s2_nxt.sum_i = (W + 1)'(s1_r.ai) + (W + 1)'(s1_r.ci);
  end

  // Stage 3: form the signed sums and turn them into sign and magnitude.
  always_comb begin
    logic signed [NW-1:0] sr;
    logic signed [NW-1:0] si;
    logic [NW-1:0]        mr;
    logic [NW-1:0]        mi;
    logic [DW-1:0]        d;
    logic                 is_div;
    logic                 is_mul;
    sr = '0;
    si = '0;
    is_div = 1'b0;
    is_mul = 1'b0;
    case (s2_r.op) inside
      OP_MUL, OP_SCALE: begin
        sr = NW'(s2_r.pr_rr) - NW'(s2_r.pr_ii);
        si = NW'(s2_r.pr_ri) + NW'(s2_r.pr_ir);
        is_mul = 1'b1;
      end
      OP_DIV: begin
        sr = NW'(s2_r.pr_rr) + NW'(s2_r.pr_ii);
        si = NW'(s2_r.pr_ir) - NW'(s2_r.pr_ri);
        is_div = 1'b1;
      end
      default: begin
        sr = NW'(s2_r.sum_r);
        si = NW'(s2_r.sum_i);
      end
    endcase
    mr = sr[NW-1] ? NW'(-sr) : NW'(sr);
    mi = si[NW-1] ? NW'(-si) : NW'(si);
    // Products drop the fraction with floor, so the magnitudes of negative values round up.
    if (is_mul) begin
      mr = sr[NW-1] ? ((mr + RND) >> F) : (mr >> F);
      mi = si[NW-1] ? ((mi + RND) >> F) : (mi >> F);
    end
    d = DW'(s2_r.sq_r) + DW'(s2_r.sq_i);
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.div    = is_div;
    s3_nxt.dz     = is_div && (d == '0);
    s3_nxt.last   = s2_r.last;
    s3_nxt.neg    = {si[NW-1], sr[NW-1]};
    s3_nxt.mag[0] = mr;
    s3_nxt.mag[1] = mi;
    s3_nxt.d      = d;
    // A zero divisor gives a zero result with no saturation.
    if (s3_nxt.dz) begin
      s3_nxt.mag = '0;
      s3_nxt.neg = '0;
    end
  end

  // Divider setup: scale the numerator, flag quotients that cannot fit in
  // QB bits, and seed the remainder with the top dividend bits.
  // Restoring division: each later stage brings down one dividend bit and
  // decides one quotient bit, for both parts at once.
  always_comb begin
    logic [XW-1:0] x;
    logic [DW:0]   t;
    dv_nxt[0].valid = s3_r.valid;
    dv_nxt[0].div   = s3_r.div;
    dv_nxt[0].dz    = s3_r.dz;
    dv_nxt[0].last  = s3_r.last;
    dv_nxt[0].neg   = s3_r.neg;
    dv_nxt[0].mag   = s3_r.mag;
    dv_nxt[0].d     = s3_r.d;
    dv_nxt[0].q     = '0;
    for (int p = 0; p < 2; p++) begin
      x = XW'(s3_r.mag[p]) << F;
      dv_nxt[0].ovf[p] = (CW'(x) >= (CW'(s3_r.d) << QB));
      dv_nxt[0].rem[p] = DW'(x >> QB);
      dv_nxt[0].xl[p]  = x[QB-1:0];
    end
    for (int k = 0; k < QB; k++) begin
      dv_nxt[k+1] = dv_r[k];
      for (int p = 0; p < 2; p++) begin
        t = {dv_r[k].rem[p], dv_r[k].xl[p][QB-1]};
        if (t >= {1'b0, dv_r[k].d}) begin
          dv_nxt[k+1].rem[p] = DW'(t - {1'b0, dv_r[k].d});
          dv_nxt[k+1].q[p]   = {dv_r[k].q[p][QB-2:0], 1'b1};
        end else begin
          dv_nxt[k+1].rem[p] = t[DW-1:0];
          dv_nxt[k+1].q[p]   = {dv_r[k].q[p][QB-2:0], 1'b0};
        end
        dv_nxt[k+1].xl[p] = dv_r[k].xl[p] << 1;
      end
    end
  end

  // Output stage: pick the magnitude and saturate each part to W bits.
  always_comb begin
    logic [NW-1:0]       m;
    logic [1:0]          satp;
    logic signed [W-1:0] res [0:1];
    for (int p = 0; p < 2; p++) begin
      if (!dv_r[QB].div || dv_r[QB].dz) begin
        m = dv_r[QB].mag[p];
      end else if (dv_r[QB].ovf[p]) begin
        m = '1;
      end else begin
        m = NW'(dv_r[QB].q[p]);
      end
      satp[p] = 1'b0;
      if (!dv_r[QB].neg[p]) begin
        if (m > POS_MAX) begin
          satp[p] = 1'b1;
          res[p]  = W'(POS_MAX);
        end else begin
          res[p]  = W'(m);
        end
      end else if (m > NEG_MAG) begin
        satp[p] = 1'b1;
        res[p]  = W'(NEG_MAG);
      end else begin
        res[p]  = W'(-m);
      end
    end
    out_valid_nxt    = dv_r[QB].valid;
    out_res_real_nxt = res[0];
    out_res_imag_nxt = res[1];
    out_sat_nxt      = |satp;
    out_dz_nxt       = dv_r[QB].dz;
    out_last_nxt     = dv_r[QB].last;
  end

  // Pipeline registers: reset clears the valid bits only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        dv_r[k].valid <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      for (int k = 0; k <= QB; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
      out_valid_r    <= out_valid_nxt;
      out_res_real_r <= out_res_real_nxt;
      out_res_imag_r <= out_res_imag_nxt;
      out_sat_r      <= out_sat_nxt;
      out_dz_r       <= out_dz_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_res_real       = out_res_real_r;
  assign out_res_imag       = out_res_imag_r;
  assign out_saturated      = out_sat_r;
  assign out_divide_by_zero = out_dz_r;
  assign out_last_out       = out_last_r;

  // Every accepted beat comes out as a result beat.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat did not come out on time");

  // No result beat appears without a matching accepted beat.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without a matching input beat");

  // A zero divisor gives a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_res_real == '0 && out_res_imag == '0 && !out_saturated))
    else $error("divide by zero result is not a clean zero");

  // Only divides can raise the zero divisor flag.
  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != OP_DIV) |-> ##LAT !out_divide_by_zero)
    else $error("zero divisor flag on a non-divide beat");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the complex element-wise ALU top level.
// Predicts every result beat in-line from the operands and constants.
// Depends on ceal_pkg and complex_elementwise_alu_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ceal_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int LATENCY = DW + 6;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    op_t op;
    logic signed [DW-1:0] ar, ai, br, bi;
    logic last;
  } alu_item_t;

  typedef struct packed {
    logic signed [DW-1:0] rr, ri;
    logic sat, dz, last;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  op_t in_operation = OP_MUL;
  logic signed [DW-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic signed [DW-1:0] out_res_real, out_res_imag;
  logic out_saturated, out_divide_by_zero, out_last_out;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = REG_CONST_REAL;
  logic [DW-1:0] cfg_wdata = '0;

  complex_elementwise_alu_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_a_real, .in_a_imag,
    .in_b_real, .in_b_imag, .in_last_in, .out_valid, .out_res_real,
    .out_res_imag, .out_saturated, .out_divide_by_zero, .out_last_out,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  // Constants as the block holds them.
  logic signed [DW-1:0] k_real = '0, k_imag = '0;

  alu_item_t pending_items[$];
  alu_result_t expected_results[$];
  int idle_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int div_zero_seen = 0;
  int sat_seen = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Saturate a wide signed value to the data width.
  function automatic logic signed [DW-1:0] clip_to_width(input logic signed [79:0] v,
                                                         inout logic sat);
    logic signed [79:0] hi, lo;
    hi = (80'sd1 <<< (DW - 1)) - 1;
    lo = -(80'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Scaled quotient of n by d, truncated toward zero.
  function automatic logic signed [79:0] scaled_quotient(input logic signed [79:0] n,
                                                         input logic signed [79:0] d);
    logic signed [79:0] mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag <<< FB) / d;
    return (n < 0) ? -q : q;
  endfunction

  // Expected result of one input beat.
  function automatic alu_result_t compute_result(input alu_item_t it);
    alu_result_t r;
    logic signed [79:0] ar, ai, br, bi, cr, ci, d, p, q;
    r = '0;
    r.last = it.last;
    ar = 80'(it.ar); ai = 80'(it.ai); br = 80'(it.br); bi = 80'(it.bi);
    cr = 80'(k_real); ci = 80'(k_imag);
    if (it.op == OP_SCALE) begin
      br = cr;
      bi = ci;
    end
    case (it.op)
      OP_MUL, OP_SCALE: begin
        p = ar * br - ai * bi;
        q = ar * bi + ai * br;
        r.rr = clip_to_width(p >>> FB, r.sat);
        r.ri = clip_to_width(q >>> FB, r.sat);
      end
      OP_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          r.rr = clip_to_width(scaled_quotient(ar * br + ai * bi, d), r.sat);
          r.ri = clip_to_width(scaled_quotient(ai * br - ar * bi, d), r.sat);
        end
      end
      default: begin
        r.rr = clip_to_width(ar + cr, r.sat);
        r.ri = clip_to_width(ai + ci, r.sat);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Driver: offers queued beats, idling at random.
  always @(posedge clk) begin
    if (rst_n && start && !busy) expected_results.push_back(compute_result(
        alu_item_t'{in_operation, in_a_real, in_a_imag, in_b_real, in_b_imag, in_last_in}));
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
      alu_item_t it;
      it = pending_items.pop_front();
      start <= 1'b1;
      in_operation <= it.op;
      in_a_real <= it.ar;
      in_a_imag <= it.ai;
      in_b_real <= it.br;
      in_b_imag <= it.bi;
      in_last_in <= it.last;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        alu_result_t e;
        e = expected_results.pop_front();
        if (out_res_real !== e.rr) report_mismatch("res_real", out_res_real, e.rr);
        if (out_res_imag !== e.ri) report_mismatch("res_imag", out_res_imag, e.ri);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
        if (out_divide_by_zero !== e.dz)
          report_mismatch("divide_by_zero", out_divide_by_zero, e.dz);
        if (out_last_out !== e.last) report_mismatch("last_out", out_last_out, e.last);
        if (e.dz) div_zero_seen++;
        if (e.sat) sat_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run after too long with work pending but no accepted or result beat.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (pending_items.size() > 0 || expected_results.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic signed [DW-1:0] edge_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'sh0100;
      4: return 16'shff00;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic alu_item_t random_item();
    alu_item_t it;
    it.op = op_t'($urandom_range(3));
    if ($urandom_range(3) == 0) begin
      it.ar = edge_value(); it.ai = edge_value();
      it.br = edge_value(); it.bi = edge_value();
    end else if ($urandom_range(1) == 0) begin
      // Moderate magnitudes keep most results in range.
      it.ar = $signed(DW'($urandom_range(2047))) - 16'sd1024;
      it.ai = $signed(DW'($urandom_range(2047))) - 16'sd1024;
      it.br = $signed(DW'($urandom_range(2047))) - 16'sd1024;
      it.bi = $signed(DW'($urandom_range(2047))) - 16'sd1024;
    end else begin
      it.ar = DW'($urandom); it.ai = DW'($urandom);
      it.br = DW'($urandom); it.bi = DW'($urandom);
    end
    if (it.op == OP_DIV && $urandom_range(15) == 0) begin
      it.br = '0;
      it.bi = '0;
    end
    it.last = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic drain_pipeline();
    while (pending_items.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_constants(input logic signed [DW-1:0] re, input logic signed [DW-1:0] im);
    cfg_we <= 1'b1;
    cfg_index <= REG_CONST_REAL;
    cfg_wdata <= re;
    @(posedge clk);
    cfg_index <= REG_CONST_IMAG;
    cfg_wdata <= im;
    @(posedge clk);
    cfg_we <= 1'b0;
    k_real = re;
    k_imag = im;
  endtask

  // Stimulus: directed beats, then random phases under varied settings.
  initial begin
    int idle_phase[4];
    logic signed [DW-1:0] consts[5][2];
    idle_phase = '{0, 47, 0, 21};
    consts = '{'{16'sh0100, 16'sh0000}, '{16'sh7fff, 16'sh7fff},
               '{16'sh8000, 16'sh8000}, '{16'sh8000, 16'sh7fff}, '{16'sh0000, 16'sh0000}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_constants(16'sh0180, 16'shff40);
    pending_items.push_back('{OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0});
    pending_items.push_back('{OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1});
    pending_items.push_back('{OP_MUL, 16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000, 1'b0});
    pending_items.push_back('{OP_MUL, 16'shffff, 16'sh0000, 16'sh0001, 16'sh0000, 1'b0});
    pending_items.push_back('{OP_DIV, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000, 1'b1});
    pending_items.push_back('{OP_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000, 1'b0});
    pending_items.push_back('{OP_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0});
    pending_items.push_back('{OP_DIV, 16'sh0001, 16'sh0000, 16'sh7fff, 16'sh7fff, 1'b0});
    pending_items.push_back('{OP_DIV, 16'shffff, 16'sh0000, 16'sh0300, 16'sh0000, 1'b1});
    pending_items.push_back('{OP_SCALE, 16'sh7fff, 16'sh8000, 16'sh1234, 16'sh5678, 1'b0});
    pending_items.push_back('{OP_ADD, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1});
    pending_items.push_back('{OP_ADD, 16'sh0000, 16'sh0000, 16'shffff, 16'shffff, 1'b0});
    drain_pipeline();
    for (int ph = 0; ph < 5; ph++) begin
      write_constants(consts[ph][0], consts[ph][1]);
      idle_pct = idle_phase[ph % 4];
      for (int n = 0; n < 40; n++) pending_items.push_back(random_item());
      drain_pipeline();
      write_constants(DW'($urandom), DW'($urandom));
      for (int n = 0; n < 80; n++) pending_items.push_back(random_item());
      drain_pipeline();
    end
    $display("checked %0d result beats over four operations and eleven constant settings",
             results_seen);
    $display("%0d divide-by-zero beats, %0d saturated beats", div_zero_seen, sat_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
